@@ hw/rtl/bpd_pkg.sv @@
// Shared widths, limits and result type for the baseline pulse detector.
package bpd_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int INDEX_W   = 16;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;

    localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [INDEX_W-1:0]  index_t;

    // Packed so that pulse_start lands in the lowest bits of m_tdata.
    typedef struct packed {
        index_t pulse_length;
        index_t pulse_end;
        index_t pulse_start;
    } result_t;

endpackage

@@ hw/rtl/baseline_pulse_detector_unit.sv @@
// Top level of the baseline pulse detector: input register, core and result register.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+-----------------------------------------
//  s_      | in  | s_tvalid / s_tready        | s_tdata: sample; s_tlast: last_sample
//  m_      | out | m_tvalid / m_tready        | m_tdata: start, end, length
//  cfg_    | in  | cfg_valid / cfg_ready      | cfg_data: pulse_threshold
//
// One item is accepted per cycle unless a closing item waits on a stalled result. When the
// core takes an item from the input register, it is evaluated against the window state and
// the result register loads, so m_tvalid rises as the closing item moves on. Reset is
// synchronous and clears the window state, the threshold and both valid flags. A stalled
// result only holds back items marked last; other samples flow until a last item waits.
module baseline_pulse_detector_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bpd_pkg::S_TDATA_W-1:0]   s_tdata,   // [11:0] sample, [15:12] zero
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] pulse_start, [31:16] pulse_end, [47:32] pulse_length
    output logic [bpd_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bpd_pkg::SAMPLE_W-1:0]    cfg_data
);

    logic             in_valid_reg, in_valid_next;
    bpd_pkg::sample_t in_sample_reg;
    logic             in_last_reg;
    bpd_pkg::sample_t thr_reg;

    logic             proceed;
    logic             core_fire;
    logic             res_valid;
    bpd_pkg::result_t res;
    bpd_pkg::result_t out_data;

    // A closing item may only move on when the result register is free or draining.
    assign proceed   = !in_last_reg || !m_tvalid || m_tready;
    assign core_fire = in_valid_reg && proceed;
    assign s_tready  = !in_valid_reg || proceed;
    assign cfg_ready = 1'b1;

    always_comb begin
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (core_fire) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            thr_reg      <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid && cfg_ready) begin
                thr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sample_reg <= s_tdata[bpd_pkg::SAMPLE_W-1:0];
            in_last_reg   <= s_tlast;
        end
    end

    bpd_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_fire       (core_fire),
        .sample          (in_sample_reg),
        .last_sample     (in_last_reg),
        .pulse_threshold (thr_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    bpd_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_valid),
        .res      (res),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .data     (out_data)
    );

    assign m_tdata = out_data;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !(m_tvalid && !m_tready))
        else $error("result register overwritten while stalled");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !core_fire) |=> in_valid_reg && $stable(in_sample_reg))
        else $error("stalled input item lost");

endmodule

@@ hw/rtl/bpd_core.sv @@
// Window state and per-sample pulse evaluation of the baseline pulse detector.
module bpd_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_fire,
    input  bpd_pkg::sample_t  sample,
    input  logic              last_sample,
    input  bpd_pkg::sample_t  pulse_threshold,
    output logic              res_valid,
    output bpd_pkg::result_t  res
);

    bpd_pkg::index_t  idx_reg, idx_next;
    bpd_pkg::sample_t base_reg, base_next;
    bpd_pkg::index_t  start_reg, start_next;
    bpd_pkg::index_t  end_reg, end_next;
    logic             ended_reg, ended_next;

    bpd_pkg::sample_t diff;
    logic             outside;

    always_comb begin
        diff    = (sample > base_reg) ? (sample - base_reg) : (base_reg - sample);
        outside = diff > pulse_threshold;
    end

    always_comb begin
        idx_next   = idx_reg;
        base_next  = base_reg;
        start_next = start_reg;
        end_next   = end_reg;
        ended_next = ended_reg;
        if (idx_reg == '0) begin
            base_next = sample;
        end else if (!ended_reg) begin
            if (outside) begin
                if (start_reg == '0) begin
                    start_next = idx_reg;
                end
            end else if (start_reg != '0) begin
                end_next   = idx_reg;
                ended_next = 1'b1;
            end
        end
        if (idx_reg != bpd_pkg::INDEX_MAX) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    // The result reflects the sample that closes the window.
    always_comb begin
        res_valid        = item_fire && last_sample;
        res.pulse_start  = start_next;
        res.pulse_end    = end_next;
        res.pulse_length = ended_next ? (end_next - start_next) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            base_reg  <= '0;
            start_reg <= '0;
            end_reg   <= '0;
            ended_reg <= 1'b0;
        end else if (item_fire) begin
            if (last_sample) begin
                idx_reg   <= '0;
                base_reg  <= '0;
                start_reg <= '0;
                end_reg   <= '0;
                ended_reg <= 1'b0;
            end else begin
                idx_reg   <= idx_next;
                base_reg  <= base_next;
                start_reg <= start_next;
                end_reg   <= end_next;
                ended_reg <= ended_next;
            end
        end
    end

    a_ended_order: assert property (@(posedge aclk) disable iff (!aresetn)
        ended_reg |-> (start_reg != '0) && (end_reg >= start_reg))
        else $error("pulse end recorded without a valid start");

    a_fresh_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg == '0) |-> (start_reg == '0) && !ended_reg)
        else $error("window state not cleared at index zero");

endmodule

@@ hw/rtl/bpd_out_reg.sv @@
// Result register holding one finished item for the master side.
module bpd_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  bpd_pkg::result_t res,
    input  logic             m_tready,
    output logic             m_tvalid,
    output bpd_pkg::result_t data
);

    logic             valid_reg, valid_next;
    bpd_pkg::result_t data_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign data     = data_reg;

endmodule

@@ tb/sv/pulse_result_checker.sv @@
// Checker for the baseline pulse detector: tracks windows, predicts results and compares them.
`timescale 1ns / 100ps

module pulse_result_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [bpd_pkg::S_TDATA_W-1:0] s_tdata,   // [11:0] sample, [15:12] zero
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] pulse_start, [31:16] pulse_end, [47:32] pulse_length
    input  logic [bpd_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [bpd_pkg::SAMPLE_W-1:0]  cfg_data,
    output int                            mismatch_count,
    output int                            results_due
);

    bpd_pkg::sample_t threshold_r;
    bpd_pkg::sample_t baseline_r;
    bpd_pkg::index_t  next_index;
    bpd_pkg::index_t  start_r;
    bpd_pkg::index_t  end_r;
    logic             ended_r;
    bpd_pkg::result_t due_results[$];

    // Applies one sample to the window; returns 1 when the window closes with a result.
    function automatic bit advance_window(input bpd_pkg::sample_t smp, input logic lst,
                                          output bpd_pkg::result_t res);
        bpd_pkg::index_t  idx;
        bpd_pkg::sample_t dev;
        idx = next_index;
        res = '0;
        if (idx == '0) begin
            baseline_r = smp;
        end else if (!ended_r) begin
            dev = (smp > baseline_r) ? smp - baseline_r : baseline_r - smp;
            if (dev > threshold_r) begin
                if (start_r == '0) start_r = idx;
            end else if (start_r != '0) begin
                end_r   = idx;
                ended_r = 1'b1;
            end
        end
        if (next_index != bpd_pkg::INDEX_MAX) next_index = next_index + 1'b1;
        if (!lst) return 1'b0;
        res.pulse_start  = start_r;
        res.pulse_end    = end_r;
        res.pulse_length = ended_r ? bpd_pkg::index_t'(end_r - start_r) : '0;
        next_index = '0;
        baseline_r = '0;
        start_r    = '0;
        end_r      = '0;
        ended_r    = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_field(input string field, input bpd_pkg::index_t want,
                                input bpd_pkg::index_t got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin : track
        bpd_pkg::result_t want;
        bpd_pkg::result_t got;
        if (!aresetn) begin
            threshold_r = '0;
            next_index  = '0;
            baseline_r  = '0;
            start_r     = '0;
            end_r       = '0;
            ended_r     = 1'b0;
            due_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) threshold_r = cfg_data;
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (due_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: expected no result, got start %0d end %0d length %0d",
                             $time, got.pulse_start, got.pulse_end, got.pulse_length);
                end else begin
                    want = due_results.pop_front();
                    report_field("pulse_start", want.pulse_start, got.pulse_start);
                    report_field("pulse_end", want.pulse_end, got.pulse_end);
                    report_field("pulse_length", want.pulse_length, got.pulse_length);
                end
            end
            if (s_tvalid && s_tready) begin
                if (advance_window(s_tdata[bpd_pkg::SAMPLE_W-1:0], s_tlast, want))
                    due_results.push_back(want);
            end
        end
        results_due = due_results.size();
    end

endmodule

@@ tb/sv/baseline_pulse_detector_unit_tb.sv @@
// Testbench top for the baseline pulse detector: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module baseline_pulse_detector_unit_tb;

    localparam int SAMPLE_MAX = (1 << bpd_pkg::SAMPLE_W) - 1;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [bpd_pkg::S_TDATA_W-1:0] s_tdata   = '0;   // [11:0] sample, [15:12] zero
    logic                          s_tlast   = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    // [15:0] pulse_start, [31:16] pulse_end, [47:32] pulse_length
    logic [bpd_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [bpd_pkg::SAMPLE_W-1:0]  cfg_data  = '0;

    int               mismatch_count;
    int               results_due;
    int               src_gap_pct    = 0;
    int               sink_stall_pct = 0;
    bpd_pkg::sample_t thr_now        = '0;

    always #6 aclk = ~aclk;

    baseline_pulse_detector_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    pulse_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_item(input bpd_pkg::sample_t smp, input logic lst);
        if ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(bpd_pkg::S_TDATA_W-bpd_pkg::SAMPLE_W){1'b0}}, smp};
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Waits until the block is idle, then writes the threshold.
    task automatic set_threshold(input bpd_pkg::sample_t value);
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (results_due != 0);
        repeat (4) @(posedge aclk);
        thr_now = value;
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Picks a sample inside or outside the threshold band, often right at its edge.
    function automatic bpd_pkg::sample_t pick_sample(input bpd_pkg::sample_t base,
                                                     input logic loud);
        int b;
        int t;
        int lo;
        int hi;
        b = base;
        t = thr_now;
        if (!loud) begin
            lo = (b > t) ? b - t : 0;
            hi = (b + t < SAMPLE_MAX) ? b + t : SAMPLE_MAX;
            if ($urandom_range(3) == 0) return bpd_pkg::sample_t'($urandom_range(1) ? hi : lo);
            return bpd_pkg::sample_t'($urandom_range(hi, lo));
        end
        if (b + t + 1 <= SAMPLE_MAX && (b < t + 1 || $urandom_range(1))) begin
            if ($urandom_range(3) == 0) return bpd_pkg::sample_t'(b + t + 1);
            return bpd_pkg::sample_t'($urandom_range(SAMPLE_MAX, b + t + 1));
        end
        if (b >= t + 1) begin
            if ($urandom_range(3) == 0) return bpd_pkg::sample_t'(b - t - 1);
            return bpd_pkg::sample_t'($urandom_range(b - t - 1, 0));
        end
        return bpd_pkg::sample_t'($urandom_range(SAMPLE_MAX));
    endfunction

    // A window is a quiet stretch, a pulse, then a mix; some samples are pure noise.
    task automatic send_window(input int len);
        bpd_pkg::sample_t base;
        bpd_pkg::sample_t smp;
        int               quiet_run;
        int               loud_run;
        base      = bpd_pkg::sample_t'($urandom_range(SAMPLE_MAX));
        quiet_run = $urandom_range(len);
        loud_run  = $urandom_range(len);
        send_item(base, len == 1);
        for (int i = 1; i < len; i++) begin
            if ($urandom_range(99) < 10)
                smp = bpd_pkg::sample_t'($urandom_range(SAMPLE_MAX));
            else if (i <= quiet_run)
                smp = pick_sample(base, 1'b0);
            else if (i <= quiet_run + loud_run)
                smp = pick_sample(base, 1'b1);
            else
                smp = pick_sample(base, $urandom_range(1));
            send_item(smp, i == len - 1);
        end
    endtask

    initial begin
        int sent;
        int len;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        src_gap_pct    = 19;
        sink_stall_pct = 71;

        set_threshold(12'd50);
        // Single-sample windows carry only a baseline.
        send_item(12'd4095, 1'b1);
        send_item(12'd0, 1'b1);
        // Edge of the band, pulse above and below baseline, samples after the end.
        send_item(12'd2048, 1'b0);
        send_item(12'd2098, 1'b0);
        send_item(12'd2099, 1'b0);
        send_item(12'd1990, 1'b0);
        send_item(12'd2040, 1'b0);
        send_item(12'd4095, 1'b0);
        send_item(12'd0, 1'b1);
        // Pulse that never ends.
        send_item(12'd0, 1'b0);
        send_item(12'd4095, 1'b0);
        send_item(12'd4095, 1'b1);
        // Full-scale drop, then the closing sample ends the pulse.
        send_item(12'd4095, 1'b0);
        send_item(12'd0, 1'b0);
        send_item(12'd4095, 1'b1);
        set_threshold(12'd4095);
        send_item(12'd0, 1'b0);
        send_item(12'd4095, 1'b1);
        set_threshold(12'd0);
        send_item(12'd7, 1'b0);
        send_item(12'd7, 1'b0);
        send_item(12'd8, 1'b0);
        send_item(12'd6, 1'b0);
        send_item(12'd7, 1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            src_gap_pct    = (phase == 0) ? 19 : (phase == 1) ? 71 : 0;
            sink_stall_pct = (phase == 0) ? 71 : (phase == 1) ? 19 : 0;
            for (int batch = 0; batch < 4; batch++) begin
                unique case (batch)
                    0: set_threshold(bpd_pkg::sample_t'($urandom_range(63)));
                    1: set_threshold(bpd_pkg::sample_t'($urandom_range(SAMPLE_MAX)));
                    2: set_threshold(bpd_pkg::sample_t'((phase == 0) ? 0 :
                                     (phase == 1) ? SAMPLE_MAX : $urandom_range(1023)));
                    default: set_threshold(bpd_pkg::sample_t'($urandom_range(255)));
                endcase
                sent = 0;
                while (sent < 140) begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(48, 1) : $urandom_range(12, 1);
                    send_window(len);
                    sent += len;
                end
            end
        end

        s_tvalid <= 1'b0;
        do @(negedge aclk); while (results_due != 0);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("** baseline_pulse_detector_unit: PASSED **");
        end else begin
            $display("** baseline_pulse_detector_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("** baseline_pulse_detector_unit: FAILED **");
        $finish;
    end

endmodule
